@@ design/m61_pkg.sv @@
`default_nettype none
package m61_pkg;
    localparam int unsigned PW = 61;
    localparam logic [63:0] M61 = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] M61_X2 = 64'h3FFF_FFFF_FFFF_FFFE;

    // multiplier operand selects
    typedef enum logic [2:0] {
        OP_SQ_RE = 3'd0,
        OP_SQ_IM = 3'd1,
        OP_T00   = 3'd2,
        OP_T11   = 3'd3,
        OP_T01   = 3'd4,
        OP_T10   = 3'd5
    } mul_op_t;

    // controller to datapath
    typedef struct packed {
        logic    load;       // capture input word
        logic    mul_start;  // start one folded product
        mul_op_t op;
        logic    sq_done;    // commit square result
        logic    mul_done;   // commit gaussian multiply result
        logic    shift;      // advance exponent scan
        logic    finish;     // normalize into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic top_bit;   // current exponent msb
        logic mul_busy;
        logic mul_valid;
    } dp_stat_t;

    function automatic logic [63:0] fold61(input logic [63:0] x);
        fold61 = {61'd0, x[63:61]} + (x & M61);
    endfunction
endpackage
`default_nettype wire

@@ design/m61_stream_if.sv @@
`default_nettype none
interface m61_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] exponent;
    logic [60:0] base_real;
    logic [60:0] base_imag;
    modport source (output valid, exponent, base_real, base_imag, input ready);
    modport sink (input valid, exponent, base_real, base_imag, output ready);
endinterface

interface m61_out_if;
    logic        valid;
    logic        ready;
    logic [60:0] power_real;
    logic [60:0] power_imag;
    modport source (output valid, power_real, power_imag, input ready);
    modport sink (input valid, power_real, power_imag, output ready);
endinterface
`default_nettype wire

@@ design/m61_complex_modular_power.sv @@
`default_nettype none
// Raises the Gaussian integer base_real + i*base_imag to a 64-bit exponent
// modulo 2^61-1, one word at a time, with the result fully reduced. The
// exponent is scanned from its leading one: each remaining bit costs a
// complex square (two products) and, on a one bit, a complex multiply by the
// base (four more). Every product runs on the single shared 32x32 multiplier
// (issue, four partial products, accumulate, result). A word is accepted,
// its leading zeros are skipped and its leading one is dropped, each
// remaining bit is squared and, on a one bit, multiplied, and the result is
// loaded into the output register. The result waits in an output register;
// a new word is accepted while it waits, and the next result stalls only if
// it is still held.
module m61_complex_modular_power (
    input wire logic clk,
    input wire logic rst_n,
    m61_in_if.sink   in_ch,
    m61_out_if.source out_ch
);
    m61_pkg::dp_cmd_t  cmd;
    m61_pkg::dp_stat_t stat;

    m61_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat(stat), .cmd(cmd)
    );

    m61_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_exponent(in_ch.exponent), .in_real(in_ch.base_real),
        .in_imag(in_ch.base_imag), .out_real(out_ch.power_real),
        .out_imag(out_ch.power_imag)
    );

`ifndef SYNTHESIS
    // a pending result stays valid until it is taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    // output is always fully reduced
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.power_real != 61'h1FFF_FFFF_FFFF_FFFF &&
                          out_ch.power_imag != 61'h1FFF_FFFF_FFFF_FFFF))
        else $error("unreduced result");
    // multiplier never started while busy
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !stat.mul_busy)
        else $error("multiplier overrun");
`endif
endmodule
`default_nettype wire

@@ design/m61_mul.sv @@
`default_nettype none
// 64x64 product from four partial products of one 32x32 multiplier, then hi + lo/8
module m61_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic             valid,
    output logic [63:0]      result
);
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next, valid_reg, valid_next;
    logic [31:0]  ma, mb;
    logic [63:0]  prod_reg;
    logic [127:0] addend;
    logic [1:0]   step_reg;

    // partial product select
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            2'd1: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            2'd2: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[63:32]; mb = b_reg[63:32]; end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            2'd0: addend = {64'd0, prod_reg};
            2'd1, 2'd2: addend = {32'd0, prod_reg, 32'd0};
            default: addend = {prod_reg, 64'd0};
        endcase
    end

    // sequencing: cnt 0..3 multiply, 1..4 accumulate
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        valid_next = 1'b0;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg != 3'd0)
                acc_next = acc_reg + addend;
            if (cnt_reg == 3'd4)
            begin
                busy_next  = 1'b0;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= ma * mb;
        step_reg <= cnt_reg[1:0];
        acc_reg  <= acc_next;
    end

    assign busy   = busy_reg;
    assign valid  = valid_reg;
    assign result = acc_reg[127:64] + {3'd0, acc_reg[63:3]};
endmodule
`default_nettype wire

@@ design/m61_datapath.sv @@
`default_nettype none
module m61_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire m61_pkg::dp_cmd_t  cmd,
    output m61_pkg::dp_stat_t      stat,
    input  wire logic [63:0]       in_exponent,
    input  wire logic [60:0]       in_real,
    input  wire logic [60:0]       in_imag,
    output logic [60:0]            out_real,
    output logic [60:0]            out_imag
);
    logic [63:0] exp_reg, br_reg, bi_reg, xr_reg, xi_reg;
    logic [63:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [60:0] or_reg, oi_reg;
    logic [63:0] ma, mb, mres, nr, ni, sq_re, sq_im, gm_re, gm_im;
    logic        mbusy, mvalid;
    logic [2:0]  op_reg;

    // operand select
    always_comb
    begin
        case (cmd.op)
            m61_pkg::OP_SQ_RE:
            begin
                ma = (xr_reg + xi_reg) << 1;
                mb = (xr_reg - xi_reg + m61_pkg::M61) << 2;
            end
            m61_pkg::OP_SQ_IM: begin ma = xr_reg << 2; mb = xi_reg << 2; end
            m61_pkg::OP_T00:   begin ma = xr_reg;      mb = br_reg << 3; end
            m61_pkg::OP_T11:   begin ma = xi_reg;      mb = bi_reg << 3; end
            m61_pkg::OP_T01:   begin ma = xr_reg;      mb = bi_reg << 3; end
            default:           begin ma = xi_reg;      mb = br_reg << 3; end
        endcase
    end

    m61_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .a(ma), .b(mb),
        .busy(mbusy), .valid(mvalid), .result(mres)
    );

    assign sq_re = m61_pkg::fold61(m61_pkg::fold61(t0_reg));
    assign sq_im = m61_pkg::fold61(m61_pkg::fold61(t1_reg));
    assign gm_re = m61_pkg::fold61(m61_pkg::fold61(t0_reg - t1_reg + m61_pkg::M61_X2));
    assign gm_im = m61_pkg::fold61(m61_pkg::fold61(t3_reg + t2_reg));
    assign nr = (xr_reg >= m61_pkg::M61) ? xr_reg - m61_pkg::M61 : xr_reg;
    assign ni = (xi_reg >= m61_pkg::M61) ? xi_reg - m61_pkg::M61 : xi_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            op_reg <= cmd.op;
        if (mvalid)
        begin
            case (op_reg)
                m61_pkg::OP_SQ_RE, m61_pkg::OP_T00: t0_reg <= mres;
                m61_pkg::OP_SQ_IM, m61_pkg::OP_T11: t1_reg <= mres;
                m61_pkg::OP_T01:                    t2_reg <= mres;
                default:                            t3_reg <= mres;
            endcase
        end
        if (cmd.load)
        begin
            exp_reg <= in_exponent;
            br_reg  <= {3'd0, in_real} & m61_pkg::M61;
            bi_reg  <= {3'd0, in_imag} & m61_pkg::M61;
            // zero exponent: running value starts and stays at 1 + 0i
            xr_reg  <= (in_exponent == 64'd0) ? 64'd1 : {3'd0, in_real};
            xi_reg  <= (in_exponent == 64'd0) ? 64'd0 : {3'd0, in_imag};
        end
        else
        begin
            if (cmd.shift)
                exp_reg <= exp_reg << 1;
            if (cmd.sq_done)
            begin
                xr_reg <= sq_re;
                xi_reg <= sq_im;
            end
            if (cmd.mul_done)
            begin
                xr_reg <= gm_re;
                xi_reg <= gm_im;
            end
        end
        if (cmd.finish)
        begin
            or_reg <= nr[60:0];
            oi_reg <= ni[60:0];
        end
    end

    assign stat.exp_zero  = (exp_reg == 64'd0);
    assign stat.top_bit   = exp_reg[63];
    assign stat.mul_busy  = mbusy;
    assign stat.mul_valid = mvalid;
    assign out_real = or_reg;
    assign out_imag = oi_reg;
endmodule
`default_nettype wire

@@ design/m61_ctrl.sv @@
`default_nettype none
module m61_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire m61_pkg::dp_stat_t stat,
    output m61_pkg::dp_cmd_t      cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_ISSUE = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_SQ    = 7'b0010000,
        S_GM    = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;      // bits left below current
    logic [2:0] op_reg, op_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign out_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.op     = m61_pkg::mul_op_t'(op_reg);
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 6'd63;
                    state_next = S_FIND;
                end
            end
            // skip leading zeros, then drop the leading one
            S_FIND:
            begin
                if (stat.exp_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.shift = 1'b1;
                    if (stat.top_bit)
                    begin
                        if (cnt_reg == 6'd0)
                            state_next = S_OUT;
                        else
                        begin
                            op_next    = m61_pkg::OP_SQ_RE;
                            state_next = S_ISSUE;
                        end
                    end
                    else
                        cnt_next = cnt_reg - 6'd1;
                end
            end
            S_ISSUE:
            begin
                if (!stat.mul_busy)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.mul_valid)
                begin
                    case (op_reg)
                        m61_pkg::OP_SQ_RE:
                        begin
                            op_next = m61_pkg::OP_SQ_IM; state_next = S_ISSUE;
                        end
                        m61_pkg::OP_SQ_IM: state_next = S_SQ;
                        m61_pkg::OP_T10:   state_next = S_GM;
                        default:
                        begin
                            op_next = op_reg + 3'd1; state_next = S_ISSUE;
                        end
                    endcase
                end
            end
            S_SQ:
            begin
                cmd.sq_done = 1'b1;
                cnt_next    = cnt_reg - 6'd1;
                if (stat.top_bit)
                begin
                    op_next    = m61_pkg::OP_T00;
                    state_next = S_ISSUE;
                end
                else
                begin
                    cmd.shift = 1'b1;
                    op_next   = m61_pkg::OP_SQ_RE;
                    state_next = (cnt_reg == 6'd1) ? S_OUT : S_ISSUE;
                end
            end
            S_GM:
            begin
                cmd.mul_done = 1'b1;
                cmd.shift    = 1'b1;
                op_next      = m61_pkg::OP_SQ_RE;
                state_next   = (cnt_reg == 6'd0) ? S_OUT : S_ISSUE;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            op_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam logic [63:0] MOD = m61_pkg::M61;
    localparam int MAX_MISMATCH_PRINT = 10;
    localparam longint CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [60:0] re;
        logic [60:0] im;
    } gauss_t;

    logic clk;
    logic rst_n;

    m61_in_if  in_ch ();
    m61_out_if out_ch ();

    m61_complex_modular_power dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    gauss_t expected_powers[$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     recv_hold;
    longint cycles;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // 64x64 product folded as hi + lo/8
    function automatic logic [63:0] fold_product(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[127:64] + (p[63:0] >> 3);
    endfunction

    function automatic logic [63:0] reduce2(input logic [63:0] x);
        logic [63:0] t;
        t = {61'd0, x[63:61]} + (x & MOD);
        return {61'd0, t[63:61]} + (t & MOD);
    endfunction

    // expected base^exponent mod 2^61-1
    function automatic gauss_t gauss_power(input logic [63:0] e, input logic [60:0] bre,
                                           input logic [60:0] bim);
        logic [63:0] br, bi, xr, xi, tr, ti;
        int top;
        gauss_t r;
        br = {3'd0, bre};
        bi = {3'd0, bim};
        if (e == 0)
        begin
            r.re = 61'd1;
            r.im = 61'd0;
            return r;
        end
        top = 63;
        while (!e[top])
            top--;
        xr = br;
        xi = bi;
        for (int k = top - 1; k >= 0; k--)
        begin
            tr = fold_product((xr + xi) << 1, (xr - xi + MOD) << 2);
            ti = fold_product(xr << 2, xi << 2);
            xr = reduce2(tr);
            xi = reduce2(ti);
            if (e[k])
            begin
                tr = fold_product(xr, br << 3) - fold_product(xi, bi << 3) + m61_pkg::M61_X2;
                ti = fold_product(xi, br << 3) + fold_product(xr, bi << 3);
                xr = reduce2(tr);
                xi = reduce2(ti);
            end
        end
        if (xr >= MOD)
            xr = xr - MOD;
        if (xi >= MOD)
            xi = xi - MOD;
        r.re = xr[60:0];
        r.im = xi[60:0];
        return r;
    endfunction

    // send one word, idling at random first; valid stays up after acceptance
    // until the next word or an idle cycle replaces it
    task automatic send_word(input logic [63:0] e, input logic [60:0] re, input logic [60:0] im);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.exponent  <= e;
        in_ch.base_real <= re;
        in_ch.base_imag <= im;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_powers.push_back(gauss_power(e, re, im));
    endtask

    // receiver ready
    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        gauss_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_powers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH_PRINT)
                    $display("unexpected word re=%h im=%h", out_ch.power_real,
                             out_ch.power_imag);
            end
            else
            begin
                want = expected_powers.pop_front();
                if (want.re !== out_ch.power_real || want.im !== out_ch.power_imag)
                begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH_PRINT)
                        $display("mismatch: expected re=%h im=%h, got re=%h im=%h",
                                 want.re, want.im, out_ch.power_real, out_ch.power_imag);
                end
            end
        end
    end

    // stop offering words, then wait for every result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_powers.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [60:0] rand_part();
        case ($urandom_range(5))
            0: return 61'd0;
            1: return MOD[60:0];
            2: return MOD[60:0] - 61'd1;
            default: return 61'({$urandom(), $urandom()});
        endcase
    endfunction

    // mostly short exponents keep the run short
    function automatic logic [63:0] rand_exponent();
        logic [63:0] e;
        e = {$urandom(), $urandom()};
        case ($urandom_range(9))
            0: return e;
            1: return 64'(e[1:0]);
            2, 3: return e >> $urandom_range(63, 40);
            default: return e >> $urandom_range(60, 48);
        endcase
    endfunction

    // zero exponent, M parts, field extremes
    task automatic test_directed();
        send_word(64'd0, 61'd0, 61'd0);
        send_word(64'd0, MOD[60:0], MOD[60:0]);
        send_word(64'd1, MOD[60:0], MOD[60:0]);
        send_word(64'd1, MOD[60:0] - 61'd1, 61'd5);
        send_word(64'd2, 61'd0, 61'd1);
        send_word(64'd3, 61'd1, MOD[60:0]);
        send_word(64'd4, 61'd0, 61'd1);
        send_word(64'd5, 61'd3, 61'd4);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, MOD[60:0] - 61'd1, MOD[60:0] - 61'd1);
        send_word(64'h8000_0000_0000_0000, 61'd2, 61'd3);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, {61{1'b1}}, 61'd0);
        send_word(64'h5555_5555_5555_5555, 61'h0AAA_AAAA_AAAA_AAAA, 61'h1555_5555_5555_5555);
        send_word(MOD - 64'd1, 61'd7, 61'd11);
        send_word(64'h7, 61'h1555_5555_5555_5555, 61'h0AAA_AAAA_AAAA_AAAA);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(rand_exponent(), rand_part(), rand_part());
    endtask

    // long receiver stall while words keep coming, then drain
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            test_random(8);
        join
        wait_drained();
        repeat (20)
            @(posedge clk);
        test_random(4);
    endtask

    initial
    begin
        mismatches    = 0;
        cycles        = 0;
        recv_hold     = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 76;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.exponent  = '0;
        in_ch.base_real = '0;
        in_ch.base_imag = '0;
        out_ch.ready    = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(190);
        send_idle_pct = 76;
        recv_idle_pct = 34;
        test_random(190);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(190);

        wait_drained();
        repeat (100)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
